@@ rtl/pngad_pkg.sv @@
package pngad_pkg;

    // Walk position inside the file
    typedef enum logic [1:0] {
        PHASE_SIG  = 2'd0,
        PHASE_LEN  = 2'd1,
        PHASE_TYPE = 2'd2,
        PHASE_SKIP = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_UNDECIDED = 2'd0,
        VERDICT_ANIMATED  = 2'd1,
        VERDICT_STILL     = 2'd2
    } verdict_t;

    localparam logic [31:0] TAG_ACTL = 32'h6163_544C;
    localparam logic [31:0] TAG_IDAT = 32'h4944_4154;

    // Length field is four bytes; the type's last byte arrives at count three
    localparam logic [2:0] LEN_BYTES = 3'd4;
    localparam logic [2:0] TYPE_LAST = 3'd3;

    // CRC trails the chunk data
    localparam logic [32:0] CRC_BYTES = 33'd4;

endpackage

@@ rtl/pngad_walker.sv @@
module pngad_walker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [7:0]           data_byte,
    input  logic                 start_of_file,
    output pngad_pkg::verdict_t  verdict_next
);

    pngad_pkg::phase_t   phase_reg, phase_next;
    logic [2:0]          count_reg, count_next;
    logic [31:0]         length_reg, length_next;
    logic [23:0]         type_reg, type_next;
    logic [32:0]         skip_reg, skip_next;
    pngad_pkg::verdict_t decision_reg, decision_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= pngad_pkg::PHASE_SIG;
            count_reg    <= 3'd0;
            length_reg   <= 32'd0;
            type_reg     <= 24'd0;
            skip_reg     <= 33'd0;
            decision_reg <= pngad_pkg::VERDICT_UNDECIDED;
        end else if (take) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            length_reg   <= length_next;
            type_reg     <= type_next;
            skip_reg     <= skip_next;
            decision_reg <= decision_next;
        end
    end

    always_comb begin
        logic [2:0]  count_inc;
        logic [31:0] tag;
        logic [32:0] skip_dec;

        // Start of file restarts the walk before this byte is taken
        if (start_of_file) begin
            phase_next    = pngad_pkg::PHASE_SIG;
            count_next    = 3'd0;
            length_next   = 32'd0;
            type_next     = 24'd0;
            skip_next     = 33'd0;
            decision_next = pngad_pkg::VERDICT_UNDECIDED;
        end else begin
            phase_next    = phase_reg;
            count_next    = count_reg;
            length_next   = length_reg;
            type_next     = type_reg;
            skip_next     = skip_reg;
            decision_next = decision_reg;
        end

        count_inc = count_next + 3'd1;
        tag       = {type_next, data_byte};
        skip_dec  = (skip_next != 33'd0) ? skip_next - 33'd1 : skip_next;

        if (decision_next == pngad_pkg::VERDICT_UNDECIDED) begin
            case (phase_next)
                pngad_pkg::PHASE_SIG: begin
                    count_next = count_inc;
                    // Eight bytes wrap the count back to zero
                    if (count_inc == 3'd0) begin
                        phase_next  = pngad_pkg::PHASE_LEN;
                        length_next = 32'd0;
                    end
                end
                pngad_pkg::PHASE_LEN: begin
                    length_next = {length_next[23:0], data_byte};
                    count_next  = count_inc;
                    if (count_inc == pngad_pkg::LEN_BYTES) begin
                        phase_next = pngad_pkg::PHASE_TYPE;
                        count_next = 3'd0;
                        type_next  = 24'd0;
                    end
                end
                pngad_pkg::PHASE_TYPE: begin
                    if (count_next < pngad_pkg::TYPE_LAST) begin
                        type_next  = {type_next[15:0], data_byte};
                        count_next = count_inc;
                    end else begin
                        count_next = 3'd0;
                        if (tag == pngad_pkg::TAG_ACTL) begin
                            decision_next = pngad_pkg::VERDICT_ANIMATED;
                        end else if (tag == pngad_pkg::TAG_IDAT) begin
                            decision_next = pngad_pkg::VERDICT_STILL;
                        end else begin
                            skip_next  = {1'b0, length_next} + pngad_pkg::CRC_BYTES;
                            phase_next = pngad_pkg::PHASE_SKIP;
                        end
                    end
                end
                pngad_pkg::PHASE_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 33'd0) begin
                        phase_next  = pngad_pkg::PHASE_LEN;
                        count_next  = 3'd0;
                        length_next = 32'd0;
                    end
                end
                default: begin
                    phase_next = pngad_pkg::PHASE_SIG;
                end
            endcase
        end

        verdict_next = decision_next;
    end

endmodule

@@ rtl/png_chunk_animation_detector.sv @@
// Channel  | Direction | Ports                                   | Word
// ---------+-----------+-----------------------------------------+----------------------------
// s_       | in        | s_valid s_ready s_data_byte s_start_of_file | one file byte
// m_       | out       | m_valid m_ready m_verdict               | verdict after that byte
//
// One byte per cycle sustained while m_ready stays high; an accepted byte passes
// through the input register, then the walker update is written into the result register.
// Walker state advances only as a byte moves from the input to the result register.
// Reset (aresetn low, synchronous) empties both registers and restarts the walk.
// A stalled m_ready holds the result register; s_ready drops once the input
// register is also full.
module png_chunk_animation_detector (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_start_of_file,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_sof_reg;

    // Result register
    logic                out_valid_reg, out_valid_next;
    pngad_pkg::verdict_t out_verdict_reg;

    pngad_pkg::verdict_t verdict_next;
    logic                advance;

    // Move a byte into the result register whenever that register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold unless a new word is taken
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_sof_reg  <= s_start_of_file;
        end
        if (advance) begin
            out_verdict_reg <= verdict_next;
        end
    end

    pngad_walker u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (advance),
        .data_byte     (in_byte_reg),
        .start_of_file (in_sof_reg),
        .verdict_next  (verdict_next)
    );

    assign m_valid   = out_valid_reg;
    assign m_verdict = out_verdict_reg;

endmodule

@@ rtl/pngad_chk.sv @@
module pngad_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_data_byte,
    input logic       s_start_of_file,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_verdict
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict))
        else $error("result word changed while stalled");

    // Only the three verdict codes ever leave the block
    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict == pngad_pkg::VERDICT_UNDECIDED
                  || m_verdict == pngad_pkg::VERDICT_ANIMATED
                  || m_verdict == pngad_pkg::VERDICT_STILL))
        else $error("illegal verdict code");

    // Input backpressure comes only from a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low without output stall");

    // An empty result register always leaves room for a new byte
    a_accept_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline stalled with an empty result register");

endmodule

bind png_chunk_animation_detector pngad_chk u_pngad_chk (.*);
